// ----- sv/vfp_pkg.sv -----
// shared types and constants of the video frame packetizer
`default_nettype none
package vfp_pkg;

   localparam int unsigned MAX_FRAME_BYTES = 65536;

   localparam int unsigned LEN_W = 17;
   localparam int unsigned PKT_CFG_W = 11;
   localparam int unsigned PAYLOAD_W = 10;
   localparam int unsigned BYTE_W = 8;

   localparam logic [PKT_CFG_W-1:0] PKT_BYTES_RESET = 11'd512;
   localparam logic [PKT_CFG_W-1:0] PKT_BYTES_MIN = 11'd3;
   localparam logic [PKT_CFG_W-1:0] PKT_BYTES_MAX = 11'd1024;
   localparam logic [PKT_CFG_W-1:0] HDR_LEN_WIDE = 11'd2;

   localparam logic [BYTE_W-1:0] HDR_LEN = 8'h02;
   localparam logic [BYTE_W-1:0] FID_MASK = 8'h01;
   localparam logic [BYTE_W-1:0] EOF_BIT = 8'h02;

   // output beat position within one item's results
   localparam logic [1:0] BEAT_HDR_LEN = 2'd0;
   localparam logic [1:0] BEAT_HDR_FLAGS = 2'd1;
   localparam logic [1:0] BEAT_DATA = 2'd2;

   typedef struct packed {
      logic load;
      logic has_header;
      logic [BYTE_W-1:0] flags;
      logic [BYTE_W-1:0] data;
      logic packet_end;
      logic frame_end;
   } bundle_type;

endpackage
`default_nettype wire

// ----- sv/vfp_core.sv -----
// frame and packet counters, header decision and packet size register
`default_nettype none
module vfp_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic [vfp_pkg::BYTE_W-1:0] data_byte,
   input wire logic [vfp_pkg::LEN_W-1:0] frame_length,
   input wire logic csr_wr_en,
   input wire logic [vfp_pkg::PKT_CFG_W-1:0] csr_wr_data,
   output vfp_pkg::bundle_type bundle
);

   logic [vfp_pkg::PKT_CFG_W-1:0] packet_bytes_ff;
   logic frame_toggle_ff, frame_toggle_in;
   logic [vfp_pkg::LEN_W-1:0] sent_ff, sent_in;
   logic [vfp_pkg::PAYLOAD_W-1:0] bip_ff, bip_in;
   logic [vfp_pkg::LEN_W-1:0] latched_ff, latched_in;

   logic [vfp_pkg::PKT_CFG_W-1:0] pkt_clamped;
   logic [vfp_pkg::PKT_CFG_W-1:0] pl_wide;
   logic [vfp_pkg::PAYLOAD_W-1:0] pl;
   logic first;
   logic bad_len;
   logic [vfp_pkg::LEN_W-1:0] cur_len;
   logic [vfp_pkg::PAYLOAD_W-1:0] cur_bip;
   logic [vfp_pkg::LEN_W-1:0] remaining;
   logic [vfp_pkg::LEN_W-1:0] sent_next;
   logic [vfp_pkg::PAYLOAD_W-1:0] bip_next;
   logic hdr;
   logic eof;
   logic fe;
   logic pe;
   logic take;

   always_comb begin
      priority if (packet_bytes_ff < vfp_pkg::PKT_BYTES_MIN) begin
         pkt_clamped = vfp_pkg::PKT_BYTES_MIN;
      end else if (packet_bytes_ff > vfp_pkg::PKT_BYTES_MAX) begin
         pkt_clamped = vfp_pkg::PKT_BYTES_MAX;
      end else begin
         pkt_clamped = packet_bytes_ff;
      end
   end

   assign pl_wide = pkt_clamped - vfp_pkg::HDR_LEN_WIDE;
   assign pl = pl_wide[vfp_pkg::PAYLOAD_W-1:0];

   assign first = (sent_ff == '0);
   assign bad_len = first && ((frame_length == '0) ||
      ({15'd0, frame_length} > 32'(vfp_pkg::MAX_FRAME_BYTES)));
   assign cur_len = first ? frame_length : latched_ff;
   assign cur_bip = first ? '0 : bip_ff;
   assign hdr = (cur_bip == '0);
   assign remaining = cur_len - sent_ff;
   assign eof = (remaining <= {7'd0, pl});
   assign sent_next = sent_ff + 17'd1;
   assign bip_next = cur_bip + 10'd1;
   assign fe = (sent_next >= cur_len);
   assign pe = fe || (bip_next >= pl);
   assign take = accept && !bad_len;

   always_comb begin
      frame_toggle_in = frame_toggle_ff;
      sent_in = sent_ff;
      bip_in = bip_ff;
      latched_in = latched_ff;
      if (take) begin
         frame_toggle_in = frame_toggle_ff ^ fe;
         sent_in = fe ? '0 : sent_next;
         bip_in = pe ? '0 : bip_next;
         latched_in = fe ? '0 : cur_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_bytes_ff <= vfp_pkg::PKT_BYTES_RESET;
         frame_toggle_ff <= 1'b0;
         sent_ff <= '0;
         bip_ff <= '0;
         latched_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            packet_bytes_ff <= csr_wr_data;
         end
         frame_toggle_ff <= frame_toggle_in;
         sent_ff <= sent_in;
         bip_ff <= bip_in;
         latched_ff <= latched_in;
      end
   end

   always_comb begin
      bundle.load = take;
      bundle.has_header = hdr;
      bundle.flags = (frame_toggle_ff ? vfp_pkg::FID_MASK : 8'h00) |
                     (eof ? vfp_pkg::EOF_BIT : 8'h00);
      bundle.data = data_byte;
      bundle.packet_end = pe;
      bundle.frame_end = fe;
   end

endmodule
`default_nettype wire

// ----- sv/vfp_out.sv -----
// result register that plays out header and payload bytes one per cycle unless rsp_stall holds them
`default_nettype none
module vfp_out (
   input wire logic clock,
   input wire logic reset,
   input wire vfp_pkg::bundle_type bundle,
   output logic free,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [vfp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic rsp_is_header,
   output logic rsp_packet_end,
   output logic rsp_frame_end
);

   logic valid_ff, valid_in;
   logic [1:0] beat_ff, beat_in;
   logic [vfp_pkg::BYTE_W-1:0] flags_ff;
   logic [vfp_pkg::BYTE_W-1:0] data_ff;
   logic pe_ff;
   logic fe_ff;
   logic taken;
   logic last;

   assign taken = valid_ff && !rsp_stall;
   assign last = (beat_ff == vfp_pkg::BEAT_DATA);
   assign free = !valid_ff || (taken && last);

   always_comb begin
      valid_in = valid_ff;
      beat_in = beat_ff;
      if (bundle.load) begin
         valid_in = 1'b1;
         beat_in = bundle.has_header ? vfp_pkg::BEAT_HDR_LEN : vfp_pkg::BEAT_DATA;
      end else if (taken) begin
         if (last) begin
            valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         beat_ff <= vfp_pkg::BEAT_DATA;
      end else begin
         valid_ff <= valid_in;
         beat_ff <= beat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle.load) begin
         flags_ff <= bundle.flags;
         data_ff <= bundle.data;
         pe_ff <= bundle.packet_end;
         fe_ff <= bundle.frame_end;
      end
   end

   assign rsp_valid = valid_ff;

   always_comb begin
      unique case (beat_ff)
         vfp_pkg::BEAT_HDR_LEN: begin
            rsp_out_byte = vfp_pkg::HDR_LEN;
            rsp_is_header = 1'b1;
            rsp_packet_end = 1'b0;
            rsp_frame_end = 1'b0;
         end
         vfp_pkg::BEAT_HDR_FLAGS: begin
            rsp_out_byte = flags_ff;
            rsp_is_header = 1'b1;
            rsp_packet_end = 1'b0;
            rsp_frame_end = 1'b0;
         end
         default: begin
            rsp_out_byte = data_ff;
            rsp_is_header = 1'b0;
            rsp_packet_end = pe_ff;
            rsp_frame_end = fe_ff;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/video_frame_packetizer_unit.sv -----
// video frame packetizer top level: byte stream in, header plus payload packets out
//
//   channel  ports                                          direction
//   req      req_valid req_stall req_data_byte req_frame_length   in
//   rsp      rsp_valid rsp_stall rsp_out_byte rsp_is_header
//            rsp_packet_end rsp_frame_end                   out
//   csr      csr_wr_en csr_wr_data (packet size)            in
//
// a payload-only item yields its data byte; one that opens a packet yields header
// length, flags and data, from the result register one byte per cycle unless stalled.
// an item enters while the last byte of the previous one is taken.
// reset clears the counters, frame-id and result valid flag; packet size goes to 512.
// rsp_stall holds the current byte; req is stalled while an item is held, unless its last byte is taken.
`default_nettype none
module video_frame_packetizer_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [vfp_pkg::BYTE_W-1:0] req_data_byte,
   input wire logic [vfp_pkg::LEN_W-1:0] req_frame_length,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [vfp_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic rsp_is_header,
   output logic rsp_packet_end,
   output logic rsp_frame_end,
   input wire logic csr_wr_en,
   input wire logic [vfp_pkg::PKT_CFG_W-1:0] csr_wr_data
);

   vfp_pkg::bundle_type bundle;
   logic free;
   logic accept;

   assign req_stall = !free;
   assign accept = req_valid && free;

   vfp_core u_core (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .data_byte(req_data_byte),
      .frame_length(req_frame_length),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .bundle(bundle)
   );

   vfp_out u_out (
      .clock(clock),
      .reset(reset),
      .bundle(bundle),
      .free(free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_header(rsp_is_header),
      .rsp_packet_end(rsp_packet_end),
      .rsp_frame_end(rsp_frame_end)
   );

endmodule
`default_nettype wire
